// ===== design/rpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rpm_pkg: shared types and constants of the round panel pixel stage
// Field widths, target colours, register indexes and the side payload that
// travels with each pixel down the root pipeline.
// ----------------------------------------------------------------------------
package rpm_pkg;

	// default world size
	localparam int WORLD_W_DEF = 256;
	localparam int WORLD_H_DEF = 256;

	// field widths
	localparam int COORD_W = 8;
	localparam int COL_W   = 24;
	localparam int CH_W    = 8;
	localparam int N_W     = 9;
	localparam int N_MIN   = 8;

	// geometry widths, doubled coordinates from the crop centre
	localparam int PX_W  = 11;
	localparam int TX_W  = 12;
	localparam int ATX_W = 11;
	localparam int SQ_W  = 22;
	localparam int D2_W  = 23;
	localparam int NSQ_W = 18;

	// rim fade: root of d2 with 8 fraction bits
	localparam int FRAC_BITS = 8;
	localparam int RAD_W     = NSQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int K_W       = 10;
	localparam logic [K_W-1:0] K_MAX = K_W'(3 << FRAC_BITS);

	// grid and pip spacing
	localparam int PIP_STEP  = 10;
	localparam int PIP_RECIP = 205;
	localparam int PIP_SHIFT = 11;

	// target colours
	localparam logic [COL_W-1:0] COL_BLACK   = 24'h000000;
	localparam logic [COL_W-1:0] COL_RED     = 24'hFF2020;
	localparam logic [COL_W-1:0] COL_GREEN   = 24'h20FF20;
	localparam logic [COL_W-1:0] COL_BLUE    = 24'h4080FF;
	localparam logic [COL_W-1:0] COL_YELLOW  = 24'hFFE020;
	localparam logic [COL_W-1:0] COL_WHITE   = 24'hFFFFFF;
	localparam logic [COL_W-1:0] COL_MAGENTA = 24'hFF40FF;
	localparam logic [COL_W-1:0] COL_CROSS   = 24'h303030;
	localparam logic [COL_W-1:0] COL_GRID    = 24'h202020;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PANEL_SIZE,
		REG_CALIBRATE,
		REG_CIRCLE_MASK
	} rpm_reg_t;

	// pixel payload carried alongside the root pipeline
	typedef struct packed {
		logic             rim;
		logic [N_W-1:0]   n;
		logic [COL_W-1:0] color;
	} rpm_side_t;

endpackage

// ===== design/rpm_geom.sv =====
// ----------------------------------------------------------------------------
// rpm_geom: crop geometry, distances and alignment target
// Four stages: clamp and crop offsets, doubled coordinates, squares and
// target flags, then distance compares and colour choice.
// ----------------------------------------------------------------------------
module rpm_geom #(
	parameter int WORLD_WIDTH  = rpm_pkg::WORLD_W_DEF,
	parameter int WORLD_HEIGHT = rpm_pkg::WORLD_H_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [rpm_pkg::N_W-1:0]      panel_size,
	input  logic                         calibrate_mode,
	input  logic                         circle_mask,
	input  logic                         in_valid,
	input  logic [rpm_pkg::COORD_W-1:0]  pixel_x,
	input  logic [rpm_pkg::COORD_W-1:0]  pixel_y,
	input  logic [rpm_pkg::COL_W-1:0]    color_in,
	output logic                         out_valid,
	output rpm_pkg::rpm_side_t           out_side,
	output logic [rpm_pkg::NSQ_W-1:0]    out_d2
);
	import rpm_pkg::*;

	localparam int LIM   = (WORLD_WIDTH < WORLD_HEIGHT) ? WORLD_WIDTH : WORLD_HEIGHT;
	localparam int N_TOP = (1 << N_W) - 1;
	localparam int LIM_N = (LIM > N_TOP) ? N_TOP : LIM;
	localparam int WW    = N_W + 2;

	function automatic logic is_mult10(input logic [CH_W-1:0] v);
		logic [2*CH_W-1:0] prod;
		logic [CH_W-1:0]   q;
		logic [CH_W-1:0]   back;
		prod = (2*CH_W)'(v) * (2*CH_W)'(PIP_RECIP);
		q    = CH_W'(prod >> PIP_SHIFT);
		back = CH_W'(q * CH_W'(PIP_STEP));
		return v == back;
	endfunction

	// stage 1: clamp panel size, crop offsets
	logic [N_W-1:0]     n_c;
	logic [N_W:0]       cx_c;
	logic [N_W:0]       cy_c;

	logic               v_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [COL_W-1:0]   col_s1;
	logic [N_W-1:0]     n_s1;
	logic [N_W-1:0]     nm1_s1;
	logic [N_W:0]       cx_s1;
	logic [N_W:0]       cy_s1;
	logic               cal_s1;
	logic               msk_s1;

	always_comb begin
		if (panel_size < N_W'(N_MIN)) begin
			n_c = N_W'(N_MIN);
		end else if (panel_size > N_W'(LIM_N)) begin
			n_c = N_W'(LIM_N);
		end else begin
			n_c = panel_size;
		end
		cx_c = (N_W+1)'((WW'(WORLD_WIDTH) - WW'(n_c)) >> 1);
		cy_c = (N_W+1)'((WW'(WORLD_HEIGHT) - WW'(n_c)) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			col_s1 <= color_in;
			n_s1   <= n_c;
			nm1_s1 <= n_c - N_W'(1);
			cx_s1  <= cx_c;
			cy_s1  <= cy_c;
			cal_s1 <= calibrate_mode;
			msk_s1 <= circle_mask;
		end
	end

	// stage 2: crop-relative and doubled centred coordinates
	logic signed [PX_W-1:0] px_c;
	logic signed [PX_W-1:0] py_c;
	logic signed [TX_W-1:0] tx_c;
	logic signed [TX_W-1:0] ty_c;
	logic signed [TX_W-1:0] ntx_c;
	logic signed [TX_W-1:0] nty_c;

	logic                   v_s2;
	logic signed [PX_W-1:0] px_s2;
	logic signed [PX_W-1:0] py_s2;
	logic [ATX_W-1:0]       atx_s2;
	logic [ATX_W-1:0]       aty_s2;
	logic [N_W-1:0]         n_s2;
	logic [CH_W-1:0]        ic_s2;
	logic                   even_s2;
	logic [COL_W-1:0]       col_s2;
	logic                   cal_s2;
	logic                   msk_s2;

	always_comb begin
		px_c  = $signed(PX_W'(x_s1)) - $signed(PX_W'(cx_s1));
		py_c  = $signed(PX_W'(y_s1)) - $signed(PX_W'(cy_s1));
		tx_c  = $signed({px_c, 1'b0}) - $signed(TX_W'(nm1_s1));
		ty_c  = $signed({py_c, 1'b0}) - $signed(TX_W'(nm1_s1));
		ntx_c = -tx_c;
		nty_c = -ty_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= px_c;
			py_s2   <= py_c;
			atx_s2  <= tx_c[TX_W-1] ? ntx_c[ATX_W-1:0] : tx_c[ATX_W-1:0];
			aty_s2  <= ty_c[TX_W-1] ? nty_c[ATX_W-1:0] : ty_c[ATX_W-1:0];
			n_s2    <= n_s1;
			ic_s2   <= nm1_s1[N_W-1:1];
			even_s2 <= ~n_s1[0];
			col_s2  <= col_s1;
			cal_s2  <= cal_s1;
			msk_s2  <= msk_s1;
		end
	end

	// stage 3: squares, crop test, arm / crosshair / grid flags
	logic [N_W:0]           pxu_c;
	logic [N_W:0]           pyu_c;
	logic [N_W:0]           ic_c;
	logic [N_W:0]           ic1_c;
	logic [N_W:0]           nm3_c;
	logic                   crop_c;
	logic                   row_c;
	logic                   colm_c;
	logic [ATX_W-1:0]       stp_sel_c;
	logic [ATX_W:0]         stp_c;
	logic signed [PX_W-1:0] dx_c;
	logic signed [PX_W-1:0] dy_c;
	logic signed [PX_W-1:0] ndx_c;
	logic signed [PX_W-1:0] ndy_c;
	logic [CH_W-1:0]        adx_c;
	logic [CH_W-1:0]        ady_c;

	logic                   v_s3;
	logic [SQ_W-1:0]        tx2_s3;
	logic [SQ_W-1:0]        ty2_s3;
	logic [NSQ_W-1:0]       nsq_s3;
	logic [NSQ_W-1:0]       n2sq_s3;
	logic [NSQ_W-1:0]       n3sq_s3;
	logic                   crop_s3;
	logic                   red_s3;
	logic                   green_s3;
	logic                   blue_s3;
	logic                   yellow_s3;
	logic                   cross_s3;
	logic                   pip_s3;
	logic                   grid_s3;
	logic [N_W-1:0]         n_s3;
	logic [COL_W-1:0]       col_s3;
	logic                   cal_s3;
	logic                   msk_s3;

	always_comb begin
		pxu_c  = px_s2[N_W:0];
		pyu_c  = py_s2[N_W:0];
		ic_c   = (N_W+1)'(ic_s2);
		ic1_c  = ic_c + (N_W+1)'(1);
		nm3_c  = (N_W+1)'(n_s2) - (N_W+1)'(3);
		crop_c = !px_s2[PX_W-1] && !py_s2[PX_W-1]
			&& (pxu_c < (N_W+1)'(n_s2)) && (pyu_c < (N_W+1)'(n_s2));
		row_c  = (pyu_c == ic_c) || (even_s2 && pyu_c == ic1_c);
		colm_c = (pxu_c == ic_c) || (even_s2 && pxu_c == ic1_c);
		// crosshair step is half the doubled distance along the arm, rounded up
		stp_sel_c = row_c ? atx_s2 : aty_s2;
		stp_c  = ((ATX_W+1)'(stp_sel_c) + (ATX_W+1)'(1)) >> 1;
		dx_c   = px_s2 - $signed(PX_W'(ic_s2));
		dy_c   = py_s2 - $signed(PX_W'(ic_s2));
		ndx_c  = -dx_c;
		ndy_c  = -dy_c;
		adx_c  = dx_c[PX_W-1] ? ndx_c[CH_W-1:0] : dx_c[CH_W-1:0];
		ady_c  = dy_c[PX_W-1] ? ndy_c[CH_W-1:0] : dy_c[CH_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx2_s3    <= SQ_W'(atx_s2) * SQ_W'(atx_s2);
			ty2_s3    <= SQ_W'(aty_s2) * SQ_W'(aty_s2);
			nsq_s3    <= NSQ_W'(n_s2) * NSQ_W'(n_s2);
			n2sq_s3   <= NSQ_W'(n_s2 - N_W'(2)) * NSQ_W'(n_s2 - N_W'(2));
			n3sq_s3   <= NSQ_W'(n_s2 - N_W'(3)) * NSQ_W'(n_s2 - N_W'(3));
			crop_s3   <= crop_c;
			red_s3    <= row_c && (pxu_c >= nm3_c);
			green_s3  <= row_c && (pxu_c <= (N_W+1)'(2));
			blue_s3   <= colm_c && (pyu_c <= (N_W+1)'(2));
			yellow_s3 <= colm_c && (pyu_c >= nm3_c);
			cross_s3  <= row_c || colm_c;
			pip_s3    <= (stp_c != '0) && is_mult10(stp_c[CH_W-1:0]);
			grid_s3   <= is_mult10(adx_c) && is_mult10(ady_c);
			n_s3      <= n_s2;
			col_s3    <= col_s2;
			cal_s3    <= cal_s2;
			msk_s3    <= msk_s2;
		end
	end

	// stage 4: distance compares and colour choice
	logic [D2_W-1:0]  d2_c;
	logic             out_disc_c;
	logic             ring_c;
	logic             inner_c;
	logic [COL_W-1:0] tgt_c;
	rpm_side_t        side_c;

	logic             v_s4;
	rpm_side_t        side_s4;
	logic [NSQ_W-1:0] d2_s4;

	always_comb begin
		d2_c       = D2_W'(tx2_s3) + D2_W'(ty2_s3);
		out_disc_c = d2_c > D2_W'(nsq_s3);
		ring_c     = d2_c > D2_W'(n2sq_s3);
		inner_c    = d2_c <= D2_W'(n3sq_s3);

		if (!crop_s3 || out_disc_c) begin
			tgt_c = COL_BLACK;
		end else if (red_s3) begin
			tgt_c = COL_RED;
		end else if (green_s3) begin
			tgt_c = COL_GREEN;
		end else if (blue_s3) begin
			tgt_c = COL_BLUE;
		end else if (yellow_s3) begin
			tgt_c = COL_YELLOW;
		end else if (ring_c) begin
			tgt_c = COL_WHITE;
		end else if (cross_s3) begin
			tgt_c = pip_s3 ? COL_MAGENTA : COL_CROSS;
		end else if (grid_s3) begin
			tgt_c = COL_GRID;
		end else begin
			tgt_c = COL_BLACK;
		end

		side_c.n   = n_s3;
		side_c.rim = !cal_s3 && msk_s3 && !out_disc_c && !inner_c;
		if (cal_s3) begin
			side_c.color = tgt_c;
		end else if (msk_s3 && out_disc_c) begin
			side_c.color = COL_BLACK;
		end else begin
			side_c.color = col_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c;
			d2_s4   <= d2_c[NSQ_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign out_side  = side_s4;
	assign out_d2    = d2_s4;

endmodule

// ===== design/rpm_sqrt.sv =====
// ----------------------------------------------------------------------------
// rpm_sqrt: pipelined square root for the rim fade
// One result bit per stage, restoring digit method on d2 shifted up by
// sixteen bits; the pixel payload rides along.
// ----------------------------------------------------------------------------
module rpm_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rpm_pkg::rpm_side_t            in_side,
	input  logic [rpm_pkg::NSQ_W-1:0]     in_d2,
	output logic                          out_valid,
	output rpm_pkg::rpm_side_t            out_side,
	output logic [rpm_pkg::ROOT_W-1:0]    out_root
);
	import rpm_pkg::*;

	localparam int TR_W = RAD_W + 2;

	logic              v_s    [1:ROOT_W];
	logic [RAD_W-1:0]  rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	rpm_side_t         side_s [1:ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
		localparam int B = ROOT_W - 1 - j;

		logic              v_in;
		logic [RAD_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		rpm_side_t         side_in;
		logic [TR_W-1:0]   trial;
		logic [TR_W-1:0]   diff;
		logic              ge;

		if (j == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = {in_d2, {(2*FRAC_BITS){1'b0}}};
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = v_s[j];
			assign rem_in  = rem_s[j];
			assign root_in = root_s[j];
			assign side_in = side_s[j];
		end

		// bits of root_in sit above B, so the two terms never overlap
		assign trial = (TR_W'(root_in) << (B + 1)) | (TR_W'(1) << (2 * B));
		assign ge    = TR_W'(rem_in) >= trial;
		assign diff  = TR_W'(rem_in) - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? diff[RAD_W-1:0] : rem_in;
				root_s[j+1] <= root_in | (ROOT_W'(ge) << B);
				side_s[j+1] <= side_in;
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];

endmodule

// ===== design/rpm_scale.sv =====
// ----------------------------------------------------------------------------
// rpm_scale: linear rim fade of the pixel colour
// Fade weight from the root, per-channel product, then division by 768
// as a shift by eight and a reciprocal multiply by a third.
// ----------------------------------------------------------------------------
module rpm_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rpm_pkg::rpm_side_t            in_side,
	input  logic [rpm_pkg::ROOT_W-1:0]    in_root,
	output logic                          out_valid,
	output logic [rpm_pkg::COL_W-1:0]     out_color
);
	import rpm_pkg::*;

	localparam int P_W     = CH_W + K_W;
	localparam int Q_W     = P_W - FRAC_BITS;
	localparam int DIV3_MUL = 683;
	localparam int DIV3_SH  = 11;
	localparam int M_W     = Q_W + DIV3_SH - 1;

	// stage 1: fade weight
	logic [ROOT_W-1:0] kf_c;
	logic              v_s1;
	rpm_side_t         side_s1;
	logic [K_W-1:0]    k_s1;

	assign kf_c = {in_side.n, {FRAC_BITS{1'b0}}} - in_root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			k_s1    <= (kf_c > ROOT_W'(K_MAX)) ? K_MAX : kf_c[K_W-1:0];
		end
	end

	// stage 2: channel times weight, shifted down by eight
	logic [2:0][P_W-1:0] p_c;
	logic                v_s2;
	rpm_side_t           side_s2;
	logic [2:0][Q_W-1:0] q_s2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			p_c[c] = P_W'(side_s1.color[c*CH_W +: CH_W]) * P_W'(k_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			for (int c = 0; c < 3; c++) begin
				q_s2[c] <= p_c[c][P_W-1:FRAC_BITS];
			end
		end
	end

	// stage 3: divide by three, pick faded or plain colour
	logic [2:0][M_W-1:0] m_c;
	logic [COL_W-1:0]    fade_c;
	logic                v_s3;
	logic [COL_W-1:0]    col_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			m_c[c] = M_W'(q_s2[c]) * M_W'(DIV3_MUL);
			fade_c[c*CH_W +: CH_W] = m_c[c][DIV3_SH +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s3 <= side_s2.rim ? fade_c : side_s2.color;
		end
	end

	assign out_valid = v_s3;
	assign out_color = col_s3;

endmodule

// ===== design/round_panel_pixel_mask_and_test_pattern_core.sv =====
// ----------------------------------------------------------------------------
// round_panel_pixel_mask_and_test_pattern_core: round panel pixel stage
// Disc mask with rim fade, or an alignment target, on a pixel stream.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one pixel a beat: world column, row and rgb colour
//   m_axis returns one colour beat for every pixel beat, in order
//   cfg writes panel size, calibrate mode and circle mask by index;
//   it is always ready, and writes belong between frames with the pipe empty
// timing
//   a new pixel can be taken every cycle while s_axis_tready is high; a colour
//   reaches m_axis after its pixel beat has passed 4 geometry stages, 17 root
//   stages (one result bit each), 3 fade stages and the output register
// stalls
//   the pipeline runs while the skid register is free; when m_axis stalls
//   one more result lands in the skid register and only then s_axis_tready
//   drops, so nothing is dropped or repeated
// reset
//   arst_n clears all valid bits and the skid; registers return to panel
//   size 256 with both modes off (plain pass-through)
// ----------------------------------------------------------------------------
module round_panel_pixel_mask_and_test_pattern_core #(
	parameter int WORLD_WIDTH  = rpm_pkg::WORLD_W_DEF,
	parameter int WORLD_HEIGHT = rpm_pkg::WORLD_H_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input: pixel_x [7:0], pixel_y [15:8], color_in [39:16]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [39:0]                     s_axis_tdata,
	// colour output: color_out [23:0]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpm_pkg::N_W-1:0]         cfg_data
);
	import rpm_pkg::*;

	// configuration registers
	logic [N_W-1:0] panel_size_q;
	logic           calibrate_q;
	logic           circle_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_size_q  <= N_W'(256);
			calibrate_q   <= 1'b0;
			circle_mask_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (rpm_reg_t'(cfg_index))
				REG_PANEL_SIZE:  panel_size_q  <= cfg_data;
				REG_CALIBRATE:   calibrate_q   <= cfg_data[0];
				REG_CIRCLE_MASK: circle_mask_q <= cfg_data[0];
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// pipeline enable: the whole pipe moves while the skid register is free
	logic skid_v_q;
	logic en;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	// geometry and target
	logic             geo_valid;
	rpm_side_t        geo_side;
	logic [NSQ_W-1:0] geo_d2;

	rpm_geom #(
		.WORLD_WIDTH  (WORLD_WIDTH),
		.WORLD_HEIGHT (WORLD_HEIGHT)
	) u_geom (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.panel_size     (panel_size_q),
		.calibrate_mode (calibrate_q),
		.circle_mask    (circle_mask_q),
		.in_valid       (s_axis_tvalid),
		.pixel_x        (s_axis_tdata[7:0]),
		.pixel_y        (s_axis_tdata[15:8]),
		.color_in       (s_axis_tdata[39:16]),
		.out_valid      (geo_valid),
		.out_side       (geo_side),
		.out_d2         (geo_d2)
	);

	// twice the distance from the centre, 8 fraction bits
	logic              rt_valid;
	rpm_side_t         rt_side;
	logic [ROOT_W-1:0] rt_root;

	rpm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geo_valid),
		.in_side   (geo_side),
		.in_d2     (geo_d2),
		.out_valid (rt_valid),
		.out_side  (rt_side),
		.out_root  (rt_root)
	);

	// rim fade and final colour
	logic             res_valid;
	logic [COL_W-1:0] res_color;

	rpm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_valid),
		.in_side   (rt_side),
		.in_root   (rt_root),
		.out_valid (res_valid),
		.out_color (res_color)
	);

	// output register with skid: catches the one beat still in flight when
	// the receiver stalls, drained first once it takes again
	logic             out_v_q;
	logic [COL_W-1:0] out_data_q;
	logic [COL_W-1:0] skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_axis_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= res_valid;
			end
		end else if (en && res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_v_q) begin
			out_data_q <= skid_v_q ? skid_data_q : res_color;
		end else if (en && res_valid) begin
			skid_data_q <= res_color;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/rpm_checker.sv =====
// ----------------------------------------------------------------------------
// rpm_checker: port-level checks of the round panel pixel stage
// Output stall behaviour and input back-pressure as seen on the ports.
// ----------------------------------------------------------------------------
module rpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// back-pressure only while a result is waiting
	a_bp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output pending");

	// input stalls only after the receiver refused a beat
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without an output stall");

	// one taken output beat frees the input side
	a_bp_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |=> s_axis_tready)
		else $error("input still stalled after output was taken");

endmodule

bind round_panel_pixel_mask_and_test_pattern_core rpm_checker u_rpm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/round_panel_pixel_mask_and_test_pattern_core_tb.sv =====
// ----------------------------------------------------------------------------
// round_panel_pixel_mask_and_test_pattern_core_tb: self-checking bench
// Streams pixel beats through the round panel stage under a series of panel
// sizes and modes. Every accepted pixel is run through a local colour
// predictor, and each colour beat that comes out is compared in order.
// ----------------------------------------------------------------------------
module round_panel_pixel_mask_and_test_pattern_core_tb;
	import rpm_pkg::*;

	// register index that maps onto nothing, writes to it must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// generous cycle budget for the watchdog
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 16;
	localparam int PHASE_PIXELS = 110;
	// room for the pipe to empty, plus skid, plus margin
	localparam int TAIL_CYCLES = 40;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// ------------------------------------------------------------------------
	// colour predictor and in-order store of expected colour beats
	// ------------------------------------------------------------------------
	class colour_scoreboard;
		localparam longint FADE_SPAN = 3 * 256;

		logic [N_W-1:0]   size_reg;
		logic             calibrate_on;
		logic             mask_on;
		logic [COL_W-1:0] expected_colours[$];
		int               errors;

		function new();
			size_reg     = 9'd256;
			calibrate_on = 1'b0;
			mask_on      = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [N_W-1:0] val);
			case (idx)
				REG_PANEL_SIZE:  size_reg = val;
				REG_CALIBRATE:   calibrate_on = val[0];
				REG_CIRCLE_MASK: mask_on = val[0];
				default: ;
			endcase
		endfunction

		// register value clamped to the usable panel range
		function longint clamped_size();
			longint n, lim;
			lim = (WORLD_W_DEF < WORLD_H_DEF) ? WORLD_W_DEF : WORLD_H_DEF;
			n = longint'(size_reg);
			if (n < N_MIN) n = N_MIN;
			if (n > lim) n = lim;
			return n;
		endfunction

		function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		// floor of the square root, one result bit at a time
		function longint root_floor(longint v);
			longint root, trial;
			root = 0;
			for (int b = 20; b >= 0; b--) begin
				trial = root | (longint'(1) << b);
				if (trial * trial <= v) root = trial;
			end
			return root;
		endfunction

		function logic [COL_W-1:0] panel_colour(logic [COORD_W-1:0] x,
				logic [COORD_W-1:0] y, logic [COL_W-1:0] col);
			longint n, px, py, tx, ty, d2, ic, step, s, k;
			bit even, on_row, on_col;
			logic [COL_W-1:0] faded;
			n = clamped_size();
			px = longint'(x) - (WORLD_W_DEF - n) / 2;
			py = longint'(y) - (WORLD_H_DEF - n) / 2;
			// doubled coordinates from the crop centre
			tx = 2 * px - (n - 1);
			ty = 2 * py - (n - 1);
			d2 = tx * tx + ty * ty;
			if (calibrate_on) begin
				if (px < 0 || py < 0 || px >= n || py >= n) return COL_BLACK;
				if (d2 > n * n) return COL_BLACK;
				ic = (n - 1) / 2;
				even = (n % 2) == 0;
				on_row = (py == ic) || (even && py == ic + 1);
				on_col = (px == ic) || (even && px == ic + 1);
				if (on_row && px >= n - 3) return COL_RED;
				if (on_row && px <= 2) return COL_GREEN;
				if (on_col && py <= 2) return COL_BLUE;
				if (on_col && py >= n - 3) return COL_YELLOW;
				if (d2 > (n - 2) * (n - 2)) return COL_WHITE;
				if (on_row || on_col) begin
					step = ((on_row ? magnitude(tx) : magnitude(ty)) + 1) / 2;
					return (step > 0 && step % PIP_STEP == 0) ? COL_MAGENTA : COL_CROSS;
				end
				if (magnitude(px - ic) % PIP_STEP == 0 && magnitude(py - ic) % PIP_STEP == 0)
					return COL_GRID;
				return COL_BLACK;
			end
			if (!mask_on) return col;
			if (d2 > n * n) return COL_BLACK;
			if (d2 <= (n - 3) * (n - 3)) return col;
			// rim: linear fade over the last cell and a half, radius in q8
			s = root_floor(d2 << 16);
			k = n * 256 - s;
			if (k > FADE_SPAN) k = FADE_SPAN;
			for (int c = 0; c < 3; c++)
				faded[8*c +: 8] = 8'((longint'(col[8*c +: 8]) * k) / FADE_SPAN);
			return faded;
		endfunction

		function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				logic [COL_W-1:0] col);
			expected_colours.push_back(panel_colour(x, y, col));
		endfunction

		function void check_colour(logic [COL_W-1:0] act);
			logic [COL_W-1:0] exp_col;
			if (expected_colours.size() == 0) begin
				$error("color_out beat %06h arrived with nothing expected", act);
				errors++;
				return;
			end
			exp_col = expected_colours.pop_front();
			if (act !== exp_col) begin
				$error("color_out mismatch: expected %06h, got %06h", exp_col, act);
				errors++;
			end
		endfunction

		function int pending();
			return expected_colours.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and block ports
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// pixel_x [7:0], pixel_y [15:8], color_in [39:16]
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// color_out [23:0]
	logic [23:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [N_W-1:0] cfg_data = '0;

	colour_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int unsigned cycle_count = 0;

	always #10 clk = ~clk;

	round_panel_pixel_mask_and_test_pattern_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// colour side: check every accepted beat, then pick next cycle's ready
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_colour(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog, a hung pipe ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one register write, valid is left high for a following write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [N_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// mode registers only look at bit 0, so the upper bits carry noise
	task automatic set_registers(input logic [N_W-1:0] size, input bit calib, input bit mask);
		cfg_write(REG_PANEL_SIZE, size);
		cfg_write(REG_CALIBRATE, {8'($urandom()), calib});
		cfg_write(REG_CIRCLE_MASK, {8'($urandom()), mask});
		cfg_valid <= 1'b0;
	endtask

	// one pixel beat; valid stays high so back-to-back beats need no gap
	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COL_W-1:0] col);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {col, y, x};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(x, y, col);
	endtask

	// random idle cycles on the pixel side before the next beat
	task automatic sender_gap();
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// stop sending and let every outstanding colour come back
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 50; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 50; end
			IDLE_BOTH:     begin send_idle_pct = 10; recv_stall_pct = 10; end
		endcase
	endtask

	// pixel picker weighted towards the interesting parts of the panel:
	// noise over the whole world, plain crop, the centre cross, the rim band
	// and grid / pip positions
	task automatic pick_pixel(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
		int n, ic, sel, px, py, tx, ty, a, b;
		n   = int'(sb.clamped_size());
		ic  = (n - 1) / 2;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			px = int'($urandom_range(0, 255)) - (WORLD_W_DEF - n) / 2;
			py = int'($urandom_range(0, 255)) - (WORLD_H_DEF - n) / 2;
		end else if (sel < 40) begin
			px = $urandom_range(0, n - 1);
			py = $urandom_range(0, n - 1);
		end else if (sel < 65) begin
			// centre row or column, with near misses either side
			a = $urandom_range(0, n - 1);
			b = ic + int'($urandom_range(0, 3)) - 1;
			if ($urandom_range(0, 1)) begin px = a; py = b; end
			else begin px = b; py = a; end
		end else if (sel < 85) begin
			// about one cell either side of the disc edge
			a  = $urandom_range(0, n - 1);
			tx = 2 * a - (n - 1);
			ty = int'(sb.root_floor(longint'(n * n - tx * tx))) + int'($urandom_range(0, 4)) - 2;
			b  = (ty + n - 1) / 2;
			if ($urandom_range(0, 1)) b = n - 1 - b;
			if ($urandom_range(0, 1)) begin px = a; py = b; end
			else begin px = b; py = a; end
		end else begin
			// multiples of the pip step from the centre cell, jittered by one
			px = ic + ($urandom_range(0, 1) ? 1 : -1) * PIP_STEP * int'($urandom_range(0, n / 20))
				+ int'($urandom_range(0, 2)) - 1;
			py = ic + ($urandom_range(0, 1) ? 1 : -1) * PIP_STEP * int'($urandom_range(0, n / 20))
				+ int'($urandom_range(0, 2)) - 1;
		end
		x = 8'(px + (WORLD_W_DEF - n) / 2);
		y = 8'(py + (WORLD_H_DEF - n) / 2);
	endtask

	function automatic logic [N_W-1:0] pick_size();
		logic [N_W-1:0] odd_sizes[5] = '{9'd0, 9'd7, 9'd16, 9'd255, 9'd257};
		if ($urandom_range(0, 3) == 0) return odd_sizes[$urandom_range(0, 4)];
		return N_W'($urandom_range(N_MIN, WORLD_W_DEF));
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [N_W-1:0] fixed_sizes[6] = '{9'd8, 9'd256, 9'd9, 9'd511, 9'd0, 9'd255};
		logic [N_W-1:0] size;
		logic [COORD_W-1:0] x, y;
		logic [COL_W-1:0] col;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state is plain pass-through, corners of the field ranges
		send_pixel(8'd0, 8'd0, 24'h000000);
		send_pixel(8'd255, 8'd255, 24'hFFFFFF);
		send_pixel(8'hAA, 8'h55, 24'hA5A5A5);
		send_pixel(8'h55, 8'hAA, 24'h5A5A5A);
		drain_pipe();

		// full-size target; a stray write to the spare index must not land
		set_registers(9'd256, 1'b1, 1'b0);
		@(posedge clk);
		cfg_write(REG_UNUSED, 9'd9);
		cfg_valid <= 1'b0;
		send_pixel(8'd255, 8'd127, 24'h123456);   // right arm
		send_pixel(8'd0, 8'd128, 24'h123456);     // left arm, second centre row
		send_pixel(8'd127, 8'd0, 24'h123456);     // top arm
		send_pixel(8'd128, 8'd255, 24'h123456);   // bottom arm
		send_pixel(8'd0, 8'd0, 24'h123456);       // corner, outside the disc
		send_pixel(8'd0, 8'd126, 24'h123456);     // outer ring
		send_pixel(8'd137, 8'd127, 24'h123456);   // pip on the crosshair
		send_pixel(8'd130, 8'd127, 24'h123456);   // plain crosshair
		send_pixel(8'd137, 8'd137, 24'h123456);   // grid point
		send_pixel(8'd131, 8'd135, 24'h123456);   // empty inside the disc
		send_pixel(8'd127, 8'd127, 24'h123456);   // centre cell
		drain_pipe();

		// smallest panel, pixels outside and inside the crop
		set_registers(9'd8, 1'b1, 1'b0);
		send_pixel(8'd0, 8'd0, 24'hFFFFFF);
		send_pixel(8'd125, 8'd126, 24'hFFFFFF);
		send_pixel(8'd128, 8'd128, 24'hFFFFFF);
		drain_pipe();

		// circle mask: rim fade, outside, inside
		set_registers(9'd256, 1'b0, 1'b1);
		send_pixel(8'd0, 8'd127, 24'hFFFFFF);
		send_pixel(8'd0, 8'd0, 24'hFFFFFF);
		send_pixel(8'd127, 8'd127, 24'hFFFFFF);
		drain_pipe();

		// odd panel size under the mask
		set_registers(9'd9, 1'b0, 1'b1);
		send_pixel(8'd123, 8'd127, 24'hFF80FF);
		send_pixel(8'd131, 8'd127, 24'h80FF01);
		drain_pipe();

		// random phases: every mode against every idling pattern, and the
		// drain before each register change holds the sender until the pipe
		// has emptied
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			size = (ph < 6) ? fixed_sizes[ph] : pick_size();
			set_registers(size, (ph % 4 == 1) || (ph % 4 == 3), (ph % 4) >= 2);
			set_idle(idle_mode_t'((ph + ph / 4) % 4));
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				sender_gap();
				pick_pixel(x, y);
				col = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom());
				send_pixel(x, y, col);
			end
			drain_pipe();
		end

		// quiet tail to catch any beat that should never have come
		set_idle(IDLE_NONE);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
